FILE: hdl/des_pkg.sv
// shared constants for the disk elevator scheduler
package des_pkg;

	localparam int MAX_REQUESTS_DEF = 32;
	localparam int CYL_BITS_DEF     = 16;

	localparam int CYL_W    = 16;
	localparam int SEEK_W   = 22;
	localparam int APB_AW   = 3;
	localparam int APB_DW   = 32;

	localparam logic [SEEK_W-1:0] SEEK_MAX = {SEEK_W{1'b1}};

	typedef enum logic [0:0] {
		REG_START_HEAD = 1'b0,
		REG_SWEEP_UP   = 1'b1
	} reg_idx_t;

endpackage

FILE: hdl/des_cfg.sv
// configuration registers behind the apb port
module des_cfg (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [des_pkg::APB_AW-1:0]  paddr,
	input  logic [des_pkg::APB_DW-1:0]  pwdata,
	output logic [des_pkg::APB_DW-1:0]  prdata,
	output logic                        pready,
	output logic [des_pkg::CYL_W-1:0]   start_head,
	output logic                        sweep_up
);

	logic [des_pkg::CYL_W-1:0] head_q;
	logic                      sweep_q;
	logic                      wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			sweep_q <= 1'b1;
		end else if (wr_en) begin
			case (paddr[2])
				des_pkg::REG_START_HEAD: head_q  <= pwdata[des_pkg::CYL_W-1:0];
				des_pkg::REG_SWEEP_UP:   sweep_q <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			des_pkg::REG_START_HEAD:
				prdata = {{(des_pkg::APB_DW-des_pkg::CYL_W){1'b0}}, head_q};
			des_pkg::REG_SWEEP_UP:
				prdata = {{(des_pkg::APB_DW-1){1'b0}}, sweep_q};
			default:
				prdata = '0;
		endcase
	end

	assign start_head = head_q;
	assign sweep_up   = sweep_q;

endmodule

FILE: hdl/des_store.sv
// request store, one write port and one registered read port
module des_store #(
	parameter int DEPTH = des_pkg::MAX_REQUESTS_DEF,
	parameter int CW    = des_pkg::CYL_BITS_DEF,
	localparam int IW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic          clk,
	input  logic          we,
	input  logic [IW-1:0] waddr,
	input  logic [CW-1:0] wdata,
	input  logic [IW-1:0] raddr,
	output logic [CW-1:0] rdata
);

	logic [CW-1:0] mem [DEPTH];
	logic [CW-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

FILE: hdl/des_ctrl.sv
// batch loading, scan sequencer and visit output registers
module des_ctrl #(
	parameter int MAX_REQUESTS = des_pkg::MAX_REQUESTS_DEF,
	parameter int CYL_BITS     = des_pkg::CYL_BITS_DEF,
	localparam int IW          = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1,
	localparam int CW          = CYL_BITS
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic [des_pkg::CYL_W-1:0]    cylinder,
	input  logic                         batch_end,
	input  logic [des_pkg::CYL_W-1:0]    cfg_head,
	input  logic                         cfg_sweep,
	output logic                         mem_we,
	output logic [IW-1:0]                mem_waddr,
	output logic [CW-1:0]                mem_wdata,
	output logic [IW-1:0]                mem_raddr,
	input  logic [CW-1:0]                mem_rdata,
	output logic                         visit_strobe,
	output logic [des_pkg::CYL_W-1:0]    visit_cylinder,
	output logic [des_pkg::SEEK_W-1:0]   total_seek,
	output logic                         visit_last,
	output logic                         dropped
);

	localparam int CNTW = $clog2(MAX_REQUESTS + 1);
	localparam int SUMW = ((CW > des_pkg::SEEK_W) ? CW : des_pkg::SEEK_W) + 1;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_HEAD = 3'b010,
		ST_SCAN = 3'b100
	} state_t;

	state_t                       state_q;
	logic [CNTW-1:0]              cnt_q;
	logic                         ovf_q;
	logic [CW-1:0]                head_q;
	logic                         sweep_q;
	logic                         phase_q;
	logic [CNTW-1:0]              issue_q;
	logic [CNTW-1:0]              remain_q;
	logic                         found_q;
	logic [CW-1:0]                best_q;
	logic [IW-1:0]                best_idx_q;
	logic [CW-1:0]                at_q;
	logic [MAX_REQUESTS-1:0]      used_q;
	logic                         rd_vld_s1;
	logic [IW-1:0]                rd_idx_s1;
	logic                         strobe_q;
	logic [des_pkg::CYL_W-1:0]    visit_q;
	logic [des_pkg::SEEK_W-1:0]   seek_q;
	logic                         last_q;
	logic                         drop_q;

	logic                         accept;
	logic                         has_room;
	logic [CW+des_pkg::CYL_W-1:0] cyl_ext;
	logic [CW+des_pkg::CYL_W-1:0] head_ext;
	logic [CW+des_pkg::CYL_W-1:0] best_ext;
	logic [CW+des_pkg::CYL_W-1:0] hq_ext;
	logic                         issuing;
	logic                         scan_done;
	logic                         asc;
	logic                         ge;
	logic                         better;
	logic                         take;
	logic [CW-1:0]                travel;
	logic [SUMW-1:0]              sum;

	assign busy     = (state_q != ST_IDLE);
	assign accept   = start && (state_q == ST_IDLE);
	assign has_room = (cnt_q < CNTW'(MAX_REQUESTS));
	assign cyl_ext  = {{CW{1'b0}}, cylinder};
	assign head_ext = {{CW{1'b0}}, cfg_head};
	assign best_ext = {{des_pkg::CYL_W{1'b0}}, best_q};
	assign hq_ext   = {{des_pkg::CYL_W{1'b0}}, head_q};

	assign mem_we    = accept && has_room;
	assign mem_waddr = cnt_q[IW-1:0];
	assign mem_wdata = cyl_ext[CW-1:0];
	assign mem_raddr = issue_q[IW-1:0];

	assign issuing   = (state_q == ST_SCAN) && (issue_q < cnt_q);
	assign scan_done = (state_q == ST_SCAN) && !issuing && !rd_vld_s1;

	// ascending over requests at or above the head, descending below it
	assign asc    = phase_q ^ sweep_q;
	assign ge     = (mem_rdata >= head_q);
	assign better = !found_q || (asc ? (mem_rdata < best_q) : (mem_rdata > best_q));
	assign take   = rd_vld_s1 && !used_q[rd_idx_s1] && (ge == asc) && better;

	assign travel = (best_q > at_q) ? (best_q - at_q) : (at_q - best_q);
	assign sum    = SUMW'(seek_q) + SUMW'(travel);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			cnt_q     <= '0;
			ovf_q     <= 1'b0;
			phase_q   <= 1'b0;
			issue_q   <= '0;
			remain_q  <= '0;
			found_q   <= 1'b0;
			used_q    <= '0;
			rd_vld_s1 <= 1'b0;
			strobe_q  <= 1'b0;
		end else begin
			strobe_q  <= (state_q == ST_HEAD) || (scan_done && found_q);
			rd_vld_s1 <= issuing;
			if (issuing) begin
				issue_q <= issue_q + 1'b1;
			end
			if (take) begin
				found_q <= 1'b1;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (has_room) begin
							cnt_q <= cnt_q + 1'b1;
						end else begin
							ovf_q <= 1'b1;
						end
						if (batch_end) begin
							state_q <= ST_HEAD;
						end
					end
				end
				ST_HEAD: begin
					used_q   <= '0;
					remain_q <= cnt_q;
					phase_q  <= 1'b0;
					issue_q  <= '0;
					found_q  <= 1'b0;
					if (cnt_q == '0) begin
						state_q <= ST_IDLE;
						ovf_q   <= 1'b0;
					end else begin
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (scan_done) begin
						issue_q <= '0;
						found_q <= 1'b0;
						if (found_q) begin
							used_q[best_idx_q] <= 1'b1;
							remain_q           <= remain_q - 1'b1;
							if (remain_q == CNTW'(1)) begin
								state_q <= ST_IDLE;
								cnt_q   <= '0;
								ovf_q   <= 1'b0;
							end
						end else if (!phase_q) begin
							phase_q <= 1'b1;
						end else begin
							state_q <= ST_IDLE;
							cnt_q   <= '0;
							ovf_q   <= 1'b0;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept && batch_end) begin
			head_q  <= head_ext[CW-1:0];
			sweep_q <= cfg_sweep;
		end
		if (take) begin
			best_q     <= mem_rdata;
			best_idx_q <= rd_idx_s1;
		end
		rd_idx_s1 <= issue_q[IW-1:0];
		if (state_q == ST_HEAD) begin
			at_q    <= head_q;
			visit_q <= hq_ext[des_pkg::CYL_W-1:0];
			seek_q  <= '0;
			last_q  <= (cnt_q == '0);
			drop_q  <= ovf_q;
		end else if (scan_done && found_q) begin
			at_q    <= best_q;
			visit_q <= best_ext[des_pkg::CYL_W-1:0];
			if (sum > SUMW'(des_pkg::SEEK_MAX)) begin
				seek_q <= des_pkg::SEEK_MAX;
			end else begin
				seek_q <= sum[des_pkg::SEEK_W-1:0];
			end
			last_q  <= (remain_q == CNTW'(1));
			drop_q  <= ovf_q;
		end
	end

	assign visit_strobe   = strobe_q;
	assign visit_cylinder = visit_q;
	assign total_seek     = seek_q;
	assign visit_last     = last_q;
	assign dropped        = drop_q;

endmodule

FILE: hdl/disk_elevator_scheduler_unit.sv
// top level of the look disk scheduler
//
// channel   direction  handshake                    payload
// request   in         start & !busy                cylinder, batch_end
// visit     out        visit_strobe (one cycle)     visit_cylinder, total_seek,
//                                                   visit_last, dropped
// config    in         apb write (psel/penable)     start_head @0x0, sweep_up @0x4
//
// a request is written to the store as it is accepted; busy stays low while a batch
// is loading. after the batch_end item the sequencer registers the head visit in its
// head state, then finds each further visit in one pass over the store, plus at most
// one extra pass when the sweep turns.
// the store has one read port, which sets the pass length.
// reset clears the batch count, the overflow flag and the sequencer; the receiver
// cannot stall, each visit is on the ports for exactly one cycle.
module disk_elevator_scheduler_unit #(
	parameter int MAX_REQUESTS = des_pkg::MAX_REQUESTS_DEF,
	parameter int CYL_BITS     = des_pkg::CYL_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [des_pkg::CYL_W-1:0]     cylinder,
	input  logic                          batch_end,
	output logic                          visit_strobe,
	output logic [des_pkg::CYL_W-1:0]     visit_cylinder,
	output logic [des_pkg::SEEK_W-1:0]    total_seek,
	output logic                          visit_last,
	output logic                          dropped,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [des_pkg::APB_AW-1:0]    paddr,
	input  logic [des_pkg::APB_DW-1:0]    pwdata,
	output logic [des_pkg::APB_DW-1:0]    prdata,
	output logic                          pready
);

	localparam int IW = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1;

	logic [des_pkg::CYL_W-1:0] cfg_head;
	logic                      cfg_sweep;
	logic                      mem_we;
	logic [IW-1:0]             mem_waddr;
	logic [CYL_BITS-1:0]       mem_wdata;
	logic [IW-1:0]             mem_raddr;
	logic [CYL_BITS-1:0]       mem_rdata;

	des_cfg u_cfg (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready),
		.start_head (cfg_head),
		.sweep_up   (cfg_sweep)
	);

	des_store #(
		.DEPTH (MAX_REQUESTS),
		.CW    (CYL_BITS)
	) u_store (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	des_ctrl #(
		.MAX_REQUESTS (MAX_REQUESTS),
		.CYL_BITS     (CYL_BITS)
	) u_ctrl (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.cylinder       (cylinder),
		.batch_end      (batch_end),
		.cfg_head       (cfg_head),
		.cfg_sweep      (cfg_sweep),
		.mem_we         (mem_we),
		.mem_waddr      (mem_waddr),
		.mem_wdata      (mem_wdata),
		.mem_raddr      (mem_raddr),
		.mem_rdata      (mem_rdata),
		.visit_strobe   (visit_strobe),
		.visit_cylinder (visit_cylinder),
		.total_seek     (total_seek),
		.visit_last     (visit_last),
		.dropped        (dropped)
	);

endmodule
